FILE: hw/rtl/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg: shared types and constants for the topic subscription table
// Sizes, status codes, request modes and sequencer states.
// ----------------------------------------------------------------------------
package tst_pkg;

	localparam int Topics    = 16;
	localparam int Members   = 16;
	localparam int TW        = $clog2(Topics);
	localparam int MW        = $clog2(Members);
	localparam int MEM_DEPTH = Topics * Members;
	localparam int AW        = TW + MW;
	localparam int CW        = $clog2(Topics + 1);   // topic count width
	localparam int NW        = $clog2(Members + 1);  // member count width

	typedef enum logic [1:0] {
		MODE_SUB = 2'd0,
		MODE_REM = 2'd1,
		MODE_PUB = 2'd2,
		MODE_NOP = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_ADDED       = 3'd0,
		ST_ALREADY     = 3'd1,
		ST_CREATED     = 3'd2,
		ST_TOPICS_FULL = 3'd3,
		ST_LIST_FULL   = 3'd4,
		ST_REMOVED     = 3'd5,
		ST_DELIVERY    = 3'd6,
		ST_NO_MATCH    = 3'd7
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,      // scan topic keys
		S_DISPATCH,  // act on lookup result
		S_MREAD,     // issue member read
		S_MCHK,      // compare member read data
		S_SHIFT_RD,  // read row[j+1]
		S_SHIFT_WR,  // write row[j]
		S_RNEXT,     // next topic for remove
		S_PUB_RD,    // read member for publish
		S_PUB_OUT,   // emit delivery
		S_RESULT     // emit single result
	} state_t;

endpackage

FILE: hw/rtl/tst_ram.sv
// ----------------------------------------------------------------------------
// tst_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module tst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

FILE: hw/rtl/topic_subscription_table_top.sv
// ----------------------------------------------------------------------------
// topic_subscription_table_top: topic to subscriber membership table
// Subscribe / remove / publish over 16 topics of 16 members each.
// ----------------------------------------------------------------------------
// channel | direction | handshake       | payload
// in      | request   | in_valid/ready  | mode, topic_key, subscriber_id
// out     | result    | out_valid/ready | status, target_id, removed_count, last
//
// One request at a time; in_ready is high only when the sequencer is idle and
// no result is waiting.
// Topic lookup compares one key per cycle. Member lists sit in a single-port
// RAM, so each member visit takes an address state and a data state, and each
// shift step of a remove takes a read state and a write state. Reset clears
// the topic count, sequencer state and result valid flag; no clearing pass is
// needed. A stalled result holds the sequencer until out_ready takes it.
module topic_subscription_table_top
	import tst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [63:0] topic_key,
	input  logic [15:0] subscriber_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] target_id,
	output logic [4:0]  removed_count,
	output logic        last
);
	state_t state_q, state_d;

	// request holding registers
	mode_t       mode_q;
	logic [63:0] key_q;
	logic [15:0] sid_q;

	// topic storage: few entries, fixed-place regs plus counts
	logic [63:0]   tkey_q [Topics];
	logic [NW-1:0] mcnt_q [Topics];
	logic [CW-1:0] tused_q;

	logic [CW-1:0] ti_q;    // topic scan index (can reach Topics)
	logic [NW-1:0] j_q;     // member index
	logic [NW-1:0] n_q;     // member count of current topic
	logic          hit_q;
	logic [4:0]    rcnt_q;

	// result registers
	logic          ov_q;
	logic [2:0]    st_q;
	logic [15:0]   tid_q;
	logic          last_q;

	// RAM port
	logic          we;
	logic [AW-1:0] addr;
	logic [15:0]   wdata, rdata;

	tst_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_mem (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	logic [TW-1:0] ti;
	assign ti = ti_q[TW-1:0];

	logic key_eq;
	assign key_eq = (tkey_q[ti] == key_q);

	logic out_free;
	assign out_free = !ov_q || out_ready;

	// a new result enters the output register
	logic load_out;
	assign load_out = (state_q == S_RESULT || state_q == S_PUB_OUT) && out_free;

	assign in_ready      = (state_q == S_IDLE) && !ov_q;
	assign out_valid     = ov_q;
	assign status        = st_q;
	assign target_id     = tid_q;
	assign removed_count = (st_q == ST_REMOVED) ? rcnt_q : 5'd0;
	assign last          = last_q;

	logic accept;
	assign accept = in_valid && in_ready;

	// combinational RAM control
	always_comb begin
		we    = 1'b0;
		addr  = {ti, j_q[MW-1:0]};
		wdata = sid_q;
		unique case (state_q)
			S_DISPATCH: begin
				// new topic, or a known topic whose list was emptied by removes
				if (mode_q == MODE_SUB && ((!hit_q && tused_q < CW'(Topics))
					|| (hit_q && mcnt_q[ti] == '0))) begin
					we   = 1'b1;
					addr = {ti, {MW{1'b0}}};
				end
			end
			S_MCHK: begin
				if (mode_q == MODE_SUB && !(rdata == sid_q)
					&& j_q + NW'(1) >= n_q && n_q < NW'(Members)) begin
					we   = 1'b1;
					addr = {ti, n_q[MW-1:0]};
				end
			end
			S_SHIFT_WR: begin
				we    = 1'b1;
				wdata = rdata;
			end
			S_SHIFT_RD: addr = {ti, MW'(j_q + NW'(1))};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tused_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q    <= load_out || (ov_q && !out_ready);
			unique case (state_q)
				S_IDLE: ;
				S_DISPATCH: begin
					if (mode_q == MODE_SUB && !hit_q && tused_q < CW'(Topics))
						tused_q <= tused_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					mode_q <= mode_t'(mode);
					key_q  <= topic_key;
					sid_q  <= subscriber_id;
					ti_q   <= '0;
					hit_q  <= 1'b0;
					rcnt_q <= '0;
				end
			end
			S_FIND: begin
				if (ti_q < tused_q && key_eq) begin
					hit_q <= 1'b1;
				end else if (ti_q < tused_q) begin
					ti_q <= ti_q + CW'(1);
				end
			end
			S_DISPATCH: begin
				j_q  <= '0;
				tid_q <= '0;
				n_q  <= (mode_q == MODE_REM) ? mcnt_q[0] : hit_q ? mcnt_q[ti] : '0;
				unique case (mode_q)
					MODE_SUB: begin
						if (!hit_q) begin
							if (tused_q < CW'(Topics)) begin
								tkey_q[ti_q[TW-1:0]] <= key_q;
								mcnt_q[ti_q[TW-1:0]] <= NW'(1);
								st_q <= ST_CREATED;
							end else begin
								st_q <= ST_TOPICS_FULL;
							end
						end else if (mcnt_q[ti] == '0) begin
							mcnt_q[ti] <= NW'(1);
							st_q <= ST_ADDED;
						end
					end
					MODE_REM: begin
						ti_q <= '0;
						st_q <= ST_REMOVED;
					end
					default: st_q <= ST_NO_MATCH;
				endcase
				last_q <= 1'b1;
			end
			S_MCHK: begin
				if (rdata == sid_q) begin
					if (mode_q == MODE_SUB) st_q <= ST_ALREADY;
				end else if (j_q + NW'(1) >= n_q) begin
					if (mode_q == MODE_SUB) begin
						if (n_q < NW'(Members)) begin
							mcnt_q[ti] <= n_q + NW'(1);
							st_q <= ST_ADDED;
						end else begin
							st_q <= ST_LIST_FULL;
						end
					end
				end else begin
					j_q <= j_q + NW'(1);
				end
				if (rdata == sid_q && mode_q == MODE_REM) begin
					mcnt_q[ti] <= n_q - NW'(1);
					if (rcnt_q != 5'd31) rcnt_q <= rcnt_q + 5'd1;
				end
			end
			S_SHIFT_WR: j_q <= j_q + NW'(1);
			S_RNEXT: begin
				ti_q <= ti_q + CW'(1);
				j_q  <= '0;
				n_q  <= mcnt_q[TW'(ti_q + CW'(1))];
			end
			S_PUB_OUT: begin
				if (out_free) begin
					st_q   <= ST_DELIVERY;
					tid_q  <= rdata;
					last_q <= (j_q + NW'(1) == n_q);
					j_q    <= j_q + NW'(1);
				end
			end
			S_RESULT: if (out_free) tid_q <= '0;
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept)
					state_d = (mode_t'(mode) == MODE_NOP) ? S_IDLE
						: (mode_t'(mode) == MODE_REM) ? S_DISPATCH : S_FIND;
			end
			S_FIND: begin
				if (ti_q >= tused_q || key_eq) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				unique case (mode_q)
					MODE_SUB: state_d = (hit_q && mcnt_q[ti] != '0) ? S_MREAD : S_RESULT;
					MODE_REM: state_d = (tused_q == '0) ? S_RESULT
						: (mcnt_q[0] == '0) ? S_RNEXT : S_MREAD;
					default: state_d = (hit_q && mcnt_q[ti] != '0) ? S_PUB_RD : S_RESULT;
				endcase
			end
			S_MREAD: state_d = S_MCHK;
			S_MCHK: begin
				if (rdata == sid_q) begin
					state_d = (mode_q == MODE_SUB) ? S_RESULT
						: (j_q + NW'(1) < n_q) ? S_SHIFT_RD : S_RNEXT;
				end else if (j_q + NW'(1) >= n_q) begin
					state_d = (mode_q == MODE_SUB) ? S_RESULT : S_RNEXT;
				end else begin
					state_d = S_MREAD;
				end
			end
			S_SHIFT_RD: state_d = S_SHIFT_WR;
			S_SHIFT_WR: state_d = (j_q + NW'(2) < n_q) ? S_SHIFT_RD : S_RNEXT;
			S_RNEXT: begin
				if (ti_q + CW'(1) >= tused_q) state_d = S_RESULT;
				else if (mcnt_q[TW'(ti_q + CW'(1))] == '0) state_d = S_RNEXT;
				else state_d = S_MREAD;
			end
			S_PUB_RD: state_d = S_PUB_OUT;
			S_PUB_OUT: begin
				if (out_free)
					state_d = (j_q + NW'(1) == n_q) ? S_IDLE : S_PUB_RD;
			end
			S_RESULT: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end
endmodule

FILE: hw/rtl/tst_checker.sv
// ----------------------------------------------------------------------------
// tst_checker: port-level checks for the topic subscription table
// Handshake and result-field consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
module tst_checker
	import tst_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [15:0] target_id,
	input logic [4:0]  removed_count,
	input logic        last
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(target_id))
		else $error("result changed while stalled");

	a_tid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DELIVERY |-> target_id == 16'd0)
		else $error("target_id set on non-delivery");

	a_rc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_REMOVED |-> removed_count == 5'd0)
		else $error("removed_count set on non-remove");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DELIVERY |-> last)
		else $error("single result not marked last");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("ready during multi-result publish");
endmodule

bind topic_subscription_table_top tst_checker u_tst_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.target_id(target_id), .removed_count(removed_count), .last(last)
);

FILE: tb/sv/topic_subscription_table_checker.sv
// ----------------------------------------------------------------------------
// topic_subscription_table_checker: result predictor and comparator
// Watches both channels, keeps a shadow membership table, and compares every
// result against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module topic_subscription_table_checker
	import tst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [63:0] topic_key,
	input  logic [15:0] subscriber_id,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic [15:0] target_id,
	input  logic [4:0]  removed_count,
	input  logic        last,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		status_t     st;
		logic [15:0] tid;
		logic [4:0]  rcnt;
		logic        lst;
	} reply_t;

	logic [63:0] keys [Topics];
	logic [15:0] ids  [Topics][Members];
	int          cnt  [Topics];
	int          used;
	reply_t      replies [$];

	assign pending = replies.size();

	function automatic int lookup(logic [63:0] k);
		for (int t = 0; t < used; t++)
			if (keys[t] == k) return t;
		return -1;
	endfunction

	function automatic reply_t mk(status_t s, logic [15:0] i, logic [4:0] r, logic l);
		reply_t x;
		x.st = s; x.tid = i; x.rcnt = r; x.lst = l;
		return x;
	endfunction

	task automatic apply_request(mode_t m, logic [63:0] k, logic [15:0] sid);
		int t;
		int n;
		int j;
		int removed;
		bit hit;
		t = lookup(k);
		case (m)
			MODE_SUB: begin
				if (t >= 0) begin
					hit = 0;
					for (j = 0; j < cnt[t]; j++) if (ids[t][j] == sid) hit = 1;
					if (hit) replies.push_back(mk(ST_ALREADY, 0, 0, 1));
					else if (cnt[t] >= Members) replies.push_back(mk(ST_LIST_FULL, 0, 0, 1));
					else begin
						ids[t][cnt[t]] = sid;
						cnt[t]++;
						replies.push_back(mk(ST_ADDED, 0, 0, 1));
					end
				end else if (used >= Topics) begin
					replies.push_back(mk(ST_TOPICS_FULL, 0, 0, 1));
				end else begin
					keys[used] = k;
					ids[used][0] = sid;
					cnt[used] = 1;
					used++;
					replies.push_back(mk(ST_CREATED, 0, 0, 1));
				end
			end
			MODE_REM: begin
				removed = 0;
				for (int u = 0; u < used; u++) begin
					n = cnt[u];
					for (j = 0; j < n; j++) if (ids[u][j] == sid) break;
					if (j < n) begin
						for (; j + 1 < n; j++) ids[u][j] = ids[u][j+1];
						cnt[u] = n - 1;
						if (removed < 31) removed++;
					end
				end
				replies.push_back(mk(ST_REMOVED, 0, removed[4:0], 1));
			end
			MODE_PUB: begin
				n = (t >= 0) ? cnt[t] : 0;
				if (n == 0) replies.push_back(mk(ST_NO_MATCH, 0, 0, 1));
				else for (j = 0; j < n; j++)
					replies.push_back(mk(ST_DELIVERY, ids[t][j], 0, j == n - 1));
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t e;
		if (!arst_n) begin
			used = 0;
			fail_count = 0;
			replies.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (replies.size() == 0) begin
					$display("%0t: unexpected result status=%0d target=%0d removed=%0d last=%0b",
						$time, status, target_id, removed_count, last);
					fail_count++;
				end else begin
					e = replies.pop_front();
					if (status !== e.st || target_id !== e.tid ||
						removed_count !== e.rcnt || last !== e.lst) begin
						$display("%0t: expected st=%0d tid=%0d rc=%0d last=%0b, got st=%0d tid=%0d rc=%0d last=%0b",
							$time, e.st, e.tid, e.rcnt, e.lst,
							status, target_id, removed_count, last);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				apply_request(mode_t'(mode), topic_key, subscriber_id);
		end
	end

endmodule

FILE: tb/sv/topic_subscription_table_top_tb.sv
// ----------------------------------------------------------------------------
// topic_subscription_table_top_tb: stimulus and verdict for the table
// Directed corner requests, then random traffic over a small key and id pool
// so topics fill, lists fill, and removes hit; random stalls on both sides.
// ----------------------------------------------------------------------------
module topic_subscription_table_top_tb;
	import tst_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  mode = MODE_SUB;
	logic [63:0] topic_key = '0;
	logic [15:0] subscriber_id = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [2:0]  status;
	logic [15:0] target_id;
	logic [4:0]  removed_count;
	logic        last;
	int          fail_count;
	int          pending;
	int          idle_cycles = 0;
	bit          stim_done = 0;

	logic [63:0] key_pool [20];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	topic_subscription_table_top dut (.*);

	topic_subscription_table_checker chk (.*);

	// mostly short gaps, occasionally a long one
	function automatic int gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send(mode_t m, logic [63:0] k, logic [15:0] s);
		int g;
		g = gap();
		repeat (g) @(negedge clk);
		mode = m; topic_key = k; subscriber_id = s; in_valid = 1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 0;
		mode = mode_t'($urandom_range(0, 3));
		topic_key = {$urandom, $urandom};
		subscriber_id = 16'($urandom);
	endtask

	// result side back pressure
	always @(negedge clk) begin
		if ($urandom_range(0, 99) < 8) begin
			out_ready = 0;
			repeat ($urandom_range(5, 30)) @(negedge clk);
		end else begin
			out_ready = ($urandom_range(0, 3) != 0);
		end
	end

	// watchdog: nothing moving for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || stim_done && pending == 0)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("topic_subscription_table_top_tb: errors");
			$finish;
		end
	end

	initial begin
		int r;
		int k;
		for (int i = 0; i < 20; i++)
			key_pool[i] = (i == 0) ? 64'h0 : (i == 1) ? '1 : {$urandom, $urandom};
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: empty table, extremes, ignored mode, list fill
		send(MODE_PUB, key_pool[0], 16'h0);
		send(MODE_REM, '0, 16'hffff);
		send(MODE_SUB, key_pool[0], 16'h0);
		send(MODE_SUB, key_pool[0], 16'h0);
		send(MODE_SUB, key_pool[1], 16'hffff);
		send(MODE_NOP, key_pool[1], 16'h1234);
		send(MODE_PUB, key_pool[1], 16'h0);
		for (int i = 1; i < 17; i++) send(MODE_SUB, key_pool[0], 16'(i * 4099));
		send(MODE_PUB, key_pool[0], 16'h0);
		send(MODE_REM, '1, 16'h0);
		send(MODE_PUB, key_pool[0], 16'h0);

		// random: small id pool so subscriptions collide and removes hit
		for (int i = 0; i < 350; i++) begin
			r = $urandom_range(0, 99);
			k = (i < 120) ? $urandom_range(0, 19) : $urandom_range(0, 17);
			if (r < 50)
				send(MODE_SUB, key_pool[k], 16'($urandom_range(0, 23)));
			else if (r < 62)
				send(MODE_REM, {$urandom, $urandom}, 16'($urandom_range(0, 23)));
			else if (r < 92)
				send(MODE_PUB, (r < 90) ? key_pool[k] : {$urandom, $urandom},
					16'($urandom));
			else if (r < 96)
				send(MODE_SUB, key_pool[k], 16'($urandom));
			else
				send(MODE_NOP, {$urandom, $urandom}, 16'($urandom));
		end

		stim_done = 1;
		wait (pending == 0);
		repeat (600) @(posedge clk);
		if (fail_count == 0)
			$display("topic_subscription_table_top_tb: clean");
		else
			$display("topic_subscription_table_top_tb: errors");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/tst_pkg.sv
hw/rtl/tst_ram.sv
hw/rtl/topic_subscription_table_top.sv
hw/rtl/tst_checker.sv
tb/sv/topic_subscription_table_checker.sv
tb/sv/topic_subscription_table_top_tb.sv
